// File: hw/rtl/winograd_f43_filter_transform_core_macros.svh
// Assertion macros used by the filter transform back end.
`ifndef WINOGRAD_F43_FILTER_TRANSFORM_CORE_MACROS_SVH
`define WINOGRAD_F43_FILTER_TRANSFORM_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define WFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define WFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wft_pkg.sv
package wft_pkg;

  localparam int unsigned COEFF_BITS = 24;
  localparam int unsigned IDX_BITS   = 3;
  localparam int unsigned XP_BITS    = 28;
  localparam int unsigned RECIP_BITS = 29;
  localparam int unsigned RECIP_SHIFT = 32;

  localparam logic [IDX_BITS-1:0] TILE_MAX = 3'd5;
  localparam logic [3:0]          LAST_TAP = 4'd8;

  // Floor of 2^32 / 9.
  localparam logic [RECIP_BITS-1:0] RECIP_NINE = 29'd477218588;

  // Limits of 8*S + 9 that keep the rounded result inside 24 bits.
  localparam int NUM_HI     = 150994943;
  localparam int NUM_LO     = -150994944;
  localparam int XP_OFFSET  = 75497472;

  // The Winograd F(4,3) matrix G scaled by 24.
  localparam logic signed [5:0] HMAT [6][3] = '{
    '{ 6'sd6,  6'sd0,  6'sd0 },
    '{-6'sd4, -6'sd4, -6'sd4 },
    '{-6'sd4,  6'sd4, -6'sd4 },
    '{ 6'sd1,  6'sd2,  6'sd4 },
    '{ 6'sd1, -6'sd2,  6'sd4 },
    '{ 6'sd0,  6'sd0,  6'sd24}
  };

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

  typedef struct packed {
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                last;
  } tag_t;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] value;
    tag_t                         tag;
  } coeff_t;

endpackage

// File: hw/rtl/winograd_f43_filter_transform_core.sv
// Path: a filter enters the filter queue on its ninth tap; each coefficient then passes the s1, xp2 and q0 registers.
// Throughput: 36 coefficients per filter at one per cycle from the back end's issue
// counter while the result queue has room; the next filter loads with the last issue.
// A two-entry filter queue and an eight-entry result queue decouple both sides.
// Reset: asynchronous and active low; it clears tap count, sequencer, pipeline valid
// bits and queue pointers. Stored taps and queue contents are left undefined.
module winograd_f43_filter_transform_core #(
  parameter int unsigned TAP_BITS = 16,
  parameter int unsigned OQ_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [TAP_BITS-1:0]   tap_value_i,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [23:0]    coeff_value_o,
  output logic [2:0]            coeff_row_o,
  output logic [2:0]            coeff_col_o,
  output logic                  tile_last_o
);

  import wft_pkg::*;

  localparam int unsigned FW  = 9 * TAP_BITS;
  localparam int unsigned OCW = $clog2(OQ_DEPTH+1);

  logic           fq_push, fq_full, fq_pop, fq_empty;
  logic [FW-1:0]  fq_wdata, fq_rdata;
  logic           oq_push;
  logic [OCW-1:0] oq_count;
  coeff_t         oq_wdata, oq_head;

  wft_front #(.TAP_BITS(TAP_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .tap_value_i (tap_value_i),
    .full        (full),
    .fq_push_o   (fq_push),
    .fq_data_o   (fq_wdata),
    .fq_full_i   (fq_full)
  );

  wft_fifo #(.WIDTH(FW), .DEPTH(2)) u_filter_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .empty_o (fq_empty),
    .count_o ()
  );

  wft_back #(.TAP_BITS(TAP_BITS), .ODEPTH(OQ_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_empty_i (fq_empty),
    .fq_data_i  (fq_rdata),
    .fq_pop_o   (fq_pop),
    .oq_count_i (oq_count),
    .oq_push_o  (oq_push),
    .oq_data_o  (oq_wdata)
  );

  wft_fifo #(.WIDTH($bits(coeff_t)), .DEPTH(OQ_DEPTH)) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_wdata),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (oq_head),
    .empty_o (empty),
    .count_o (oq_count)
  );

  assign coeff_value_o = oq_head.value;
  assign coeff_row_o   = oq_head.tag.row;
  assign coeff_col_o   = oq_head.tag.col;
  assign tile_last_o   = oq_head.tag.last;

endmodule

// File: hw/rtl/wft_fifo.sv
module wft_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/wft_front.sv
module wft_front #(
  parameter int unsigned TAP_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  input  logic [TAP_BITS-1:0]     tap_value_i,
  output logic                    full,
  output logic                    fq_push_o,
  output logic [9*TAP_BITS-1:0]   fq_data_o,
  input  logic                    fq_full_i
);

  import wft_pkg::*;

  logic [TAP_BITS-1:0] taps_q [8];
  logic [3:0]          cnt_q, cnt_d;
  logic                accept;

  assign full      = fq_full_i;
  assign accept    = push && !fq_full_i;
  assign fq_push_o = accept && (cnt_q == LAST_TAP);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      fq_data_o[k*TAP_BITS +: TAP_BITS] = taps_q[k];
    end
    fq_data_o[8*TAP_BITS +: TAP_BITS] = tap_value_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = (cnt_q == LAST_TAP) ? '0 : cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q != LAST_TAP)) begin
      taps_q[cnt_q[2:0]] <= tap_value_i;
    end
  end

endmodule

// File: hw/rtl/wft_back.sv
`include "winograd_f43_filter_transform_core_macros.svh"

module wft_back #(
  parameter int unsigned TAP_BITS = 16,
  parameter int unsigned ODEPTH   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fq_empty_i,
  input  logic [9*TAP_BITS-1:0]       fq_data_i,
  output logic                        fq_pop_o,
  input  logic [$clog2(ODEPTH+1)-1:0] oq_count_i,
  output logic                        oq_push_o,
  output wft_pkg::coeff_t             oq_data_o
);

  import wft_pkg::*;

  localparam int unsigned LW  = TAP_BITS + 6;
  localparam int unsigned SW  = TAP_BITS + 12;
  localparam int unsigned NSW = SW + 4;
  localparam int unsigned NW  = (NSW > 30) ? NSW : 30;
  localparam int unsigned OCW = $clog2(ODEPTH+1);
  localparam int unsigned PRW = XP_BITS + RECIP_BITS;

  localparam logic signed [NW-1:0] NUM_HI_W = NW'(NUM_HI);
  localparam logic signed [NW-1:0] NUM_LO_W = NW'(NUM_LO);

  function automatic logic signed [SW-1:0] mul_h(input logic signed [SW-1:0] x,
                                                 input logic signed [5:0]    c);
    logic signed [SW-1:0] r;
    r = '0;
    case (c)
      6'sd1:   r = x;
      -6'sd1:  r = -x;
      6'sd2:   r = x <<< 1;
      -6'sd2:  r = -(x <<< 1);
      6'sd4:   r = x <<< 2;
      -6'sd4:  r = -(x <<< 2);
      6'sd6:   r = (x <<< 2) + (x <<< 1);
      -6'sd6:  r = -((x <<< 2) + (x <<< 1));
      6'sd24:  r = (x <<< 4) + (x <<< 3);
      -6'sd24: r = -((x <<< 4) + (x <<< 3));
      default: r = '0;
    endcase
    return r;
  endfunction

  bk_state_e state_q, state_d;

  logic signed [LW-1:0] left_q [6][3];
  logic signed [LW-1:0] left_d [6][3];
  logic [IDX_BITS-1:0]  row_q, row_d, col_q, col_d;

  logic                 v1_q, v2_q, v3_q;
  tag_t                 tag1_q, tag2_q, tag3_q, tag_cur;
  logic signed [SW-1:0] s1_q, s1_d;
  logic [XP_BITS-1:0]   xp2_q, xp2_d, xp3_q;
  logic [COEFF_BITS-1:0] q03_q, q0_d, q0_fix;
  logic [PRW-1:0]       prod;
  logic [XP_BITS-1:0]   rem;
  logic signed [NW-1:0] num, num_c, half;

  logic [OCW-1:0]       inflight;
  logic [OCW:0]         fill_total;
  logic                 issue, last_issue, load;

  // Left product H * g for a newly loaded filter.
  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] tap_ext;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          tap_ext = SW'($signed(fq_data_i[(k*3+j)*TAP_BITS +: TAP_BITS]));
          acc = acc + mul_h(tap_ext, HMAT[i][k]);
        end
        left_d[i][j] = acc[LW-1:0];
      end
    end
  end

  assign inflight   = OCW'(v1_q) + OCW'(v2_q) + OCW'(v3_q);
  assign fill_total = (OCW+1)'(oq_count_i) + (OCW+1)'(inflight);
  assign issue      = (state_q == BK_RUN) && (fill_total < (OCW+1)'(ODEPTH));
  assign last_issue = issue && (row_q == TILE_MAX) && (col_q == TILE_MAX);
  assign load       = !fq_empty_i && ((state_q == BK_IDLE) || last_issue);
  assign fq_pop_o   = load;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      BK_IDLE: begin
        if (load) begin
          state_d = BK_RUN;
          row_d   = '0;
          col_d   = '0;
        end
      end
      BK_RUN: begin
        if (issue) begin
          if (col_q == TILE_MAX) begin
            col_d = '0;
            row_d = (row_q == TILE_MAX) ? '0 : row_q + IDX_BITS'(1);
          end else begin
            col_d = col_q + IDX_BITS'(1);
          end
        end
        if (last_issue && !load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign tag_cur = '{row: row_q, col: col_q, last: last_issue};

  always_comb begin
    s1_d = '0;
    for (int k = 0; k < 3; k++) begin
      s1_d = s1_d + mul_h(SW'(left_q[row_q][k]), HMAT[col_q][k]);
    end
  end

  // Round 4S/9 as floor((8S + 9) / 18) after clamping to the output range.
  always_comb begin
    num = (NW'(s1_q) <<< 3) + NW'(9);
    if (num > NUM_HI_W) begin
      num_c = NUM_HI_W;
    end else if (num < NUM_LO_W) begin
      num_c = NUM_LO_W;
    end else begin
      num_c = num;
    end
    half  = (num_c >>> 1) + NW'(XP_OFFSET);
    xp2_d = half[XP_BITS-1:0];
  end

  assign prod = PRW'(xp2_q) * PRW'(RECIP_NINE);
  assign q0_d = prod[RECIP_SHIFT +: COEFF_BITS];

  always_comb begin
    rem    = xp3_q - ((XP_BITS'(q03_q) << 3) + XP_BITS'(q03_q));
    q0_fix = (rem >= XP_BITS'(9)) ? q03_q + COEFF_BITS'(1) : q03_q;
  end

  assign oq_push_o       = v3_q;
  assign oq_data_o.value = {~q0_fix[COEFF_BITS-1], q0_fix[COEFF_BITS-2:0]};
  assign oq_data_o.tag   = tag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q <= left_d;
    end
    s1_q   <= s1_d;
    tag1_q <= tag_cur;
    xp2_q  <= xp2_d;
    tag2_q <= tag1_q;
    xp3_q  <= xp2_q;
    q03_q  <= q0_d;
    tag3_q <= tag2_q;
  end

  `WFT_ASSERT(a_no_oq_overrun, fill_total <= (OCW+1)'(ODEPTH), "output queue overcommitted")
  `WFT_ASSERT(a_issue_in_run, !issue || state_q == BK_RUN, "coefficient issued while idle")
  `WFT_ASSERT(a_last_at_corner, !(v1_q && tag1_q.last) || (tag1_q.row == TILE_MAX && tag1_q.col == TILE_MAX), "last marker away from the tile corner")
  `WFT_ASSERT_NEXT(a_wrap_after_last, last_issue, row_q == '0 && col_q == '0, "tile index did not wrap")

endmodule
